// ----- sv/iuc_pkg.sv -----
// Shared types and helpers for the interval union coverage block.
`default_nettype none

package iuc_pkg;

    localparam int COORD_W = 32;
    localparam int LEN_W   = 33;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [LEN_W-1:0]   len_t;

    // One stored interval, closed [lo, hi], lo <= hi.
    typedef struct packed {
        coord_t lo;
        coord_t hi;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Sort order of the store: by start, then by end.
    function automatic logic key_less(input entry_t a, input entry_t b);
        logic r;
        if (a.lo != b.lo)
            r = (a.lo < b.lo);
        else
            r = (a.hi < b.hi);
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- sv/iuc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module iuc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  wire logic                       clk,
    input  wire logic                       wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]           wr_data,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]           rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- sv/interval_union_coverage_core.sv -----
// Top level: union coverage of a sorted interval store held in one RAM.
`default_nettype none

// Each accepted item adds the closed interval between pos_a and pos_b (either
// order) to a store kept sorted by (start, end) in a single RAM of
// MAX_INTERVALS entries; new_set empties the store first. After the insert the
// store is walked in order, overlapping intervals are merged into runs, and the
// summed run lengths come out as covered_length (33 bits, up to 2^32). If the
// store is already full the interval is dropped, dropped is set, and the
// coverage of the unchanged store is returned. One result per item. Timing:
// the sorted insert shifts entries up one at a time, each moved entry taking
// a read and then a compare and write-back; the new entry is placed by that
// compare or, at the bottom of the store, directly. The walk then reads every
// stored entry and merges it into the run, a final step closes the last run,
// and the total is handed to the output register, waiting while a stalled
// earlier result still holds it. A dropped item skips the insert. One item is
// in work at a time; item_stall is high while it is and falls as the result
// is loaded. A finished result sits in the output register, so the next
// item is taken while the result waits. The store needs no clearing pass
// after reset: only entries below the fill count are read.
module interval_union_coverage_core #(
    parameter int MAX_INTERVALS = 256
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input item channel
    input  wire logic        item_valid,
    output logic             item_stall,
    input  wire logic        new_set,
    input  wire logic [31:0] pos_a,
    input  wire logic [31:0] pos_b,
    // result item channel
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic [32:0]      covered_length,
    output logic             dropped
);

    localparam int AW    = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int CNT_W = $clog2(MAX_INTERVALS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_INTERVALS);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_INS_RD = 3'd1;  // read entry below insert slot
    localparam logic [2:0] S_INS_WR = 3'd2;  // compare, shift up or place
    localparam logic [2:0] S_WLK_RD = 3'd3;  // read entry k
    localparam logic [2:0] S_WLK_PR = 3'd4;  // merge entry k into run
    localparam logic [2:0] S_FIN    = 3'd5;  // close last run
    localparam logic [2:0] S_OUT    = 3'd6;  // hand result to output reg

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    iuc_pkg::entry_t    new_reg, new_next;
    logic               drop_reg, drop_next;
    iuc_pkg::coord_t    run_lo_reg, run_lo_next;
    iuc_pkg::coord_t    run_hi_reg, run_hi_next;
    iuc_pkg::len_t      total_reg, total_next;
    logic               out_valid_reg, out_valid_next;
    iuc_pkg::len_t      out_len_reg, out_len_next;
    logic               out_drop_reg, out_drop_next;

    // RAM port signals
    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    iuc_pkg::entry_t        ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [iuc_pkg::ENTRY_W-1:0] ram_rdata_raw;
    iuc_pkg::entry_t        ram_rdata;

    logic [CNT_W-1:0]   pos_m1;
    logic [CNT_W-1:0]   k_inc;
    logic [CNT_W-1:0]   cnt_eff;
    iuc_pkg::len_t      run_len;
    logic               out_free;

    assign ram_rdata = iuc_pkg::entry_t'(ram_rdata_raw);
    assign pos_m1    = pos_reg - CNT_ONE;
    assign k_inc     = k_reg + CNT_ONE;
    assign cnt_eff   = new_set ? '0 : count_reg;
    assign run_len   = {1'b0, run_hi_reg} - {1'b0, run_lo_reg} + iuc_pkg::len_t'(1);
    assign out_free  = !out_valid_reg || !result_stall;

    iuc_ram #(
        .WIDTH (iuc_pkg::ENTRY_W),
        .DEPTH (MAX_INTERVALS)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata_raw)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        k_next         = k_reg;
        new_next       = new_reg;
        drop_next      = drop_reg;
        run_lo_next    = run_lo_reg;
        run_hi_next    = run_hi_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg;
        out_len_next   = out_len_reg;
        out_drop_next  = out_drop_reg;
        ram_we         = 1'b0;
        ram_waddr      = pos_reg[AW-1:0];
        ram_wdata      = new_reg;
        ram_raddr      = k_reg[AW-1:0];

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    // order the endpoints
                    new_next.lo = (pos_a < pos_b) ? pos_a : pos_b;
                    new_next.hi = (pos_a < pos_b) ? pos_b : pos_a;
                    count_next  = cnt_eff;
                    pos_next    = cnt_eff;
                    k_next      = '0;
                    total_next  = '0;
                    if (cnt_eff >= CNT_MAX)
                    begin
                        drop_next  = 1'b1;
                        state_next = S_WLK_RD;
                    end
                    else
                    begin
                        drop_next  = 1'b0;
                        state_next = S_INS_RD;
                    end
                end
            end

            S_INS_RD:
            begin
                if (pos_reg == '0)
                begin
                    // reached the bottom: place new entry
                    ram_we     = 1'b1;
                    count_next = count_reg + CNT_ONE;
                    state_next = S_WLK_RD;
                end
                else
                begin
                    ram_raddr  = pos_m1[AW-1:0];
                    state_next = S_INS_WR;
                end
            end

            S_INS_WR:
            begin
                ram_we = 1'b1;
                if (iuc_pkg::key_less(new_reg, ram_rdata))
                begin
                    // shift the larger entry up one slot
                    ram_wdata  = ram_rdata;
                    pos_next   = pos_m1;
                    state_next = S_INS_RD;
                end
                else
                begin
                    count_next = count_reg + CNT_ONE;
                    state_next = S_WLK_RD;
                end
            end

            S_WLK_RD:
            begin
                state_next = S_WLK_PR;
            end

            S_WLK_PR:
            begin
                if (k_reg == '0)
                begin
                    run_lo_next = ram_rdata.lo;
                    run_hi_next = ram_rdata.hi;
                end
                else if (ram_rdata.lo <= run_hi_reg)
                begin
                    if (ram_rdata.hi > run_hi_reg)
                    begin
                        run_hi_next = ram_rdata.hi;
                    end
                end
                else
                begin
                    total_next  = total_reg + run_len;
                    run_lo_next = ram_rdata.lo;
                    run_hi_next = ram_rdata.hi;
                end
                k_next = k_inc;
                if (k_inc >= count_reg)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_WLK_RD;
                end
            end

            S_FIN:
            begin
                total_next = total_reg + run_len;
                state_next = S_OUT;
            end

            S_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_len_next   = total_reg;
                    out_drop_next  = drop_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // working and payload registers
    always_ff @(posedge clk)
    begin
        pos_reg      <= pos_next;
        k_reg        <= k_next;
        new_reg      <= new_next;
        drop_reg     <= drop_next;
        run_lo_reg   <= run_lo_next;
        run_hi_reg   <= run_hi_next;
        total_reg    <= total_next;
        out_len_reg  <= out_len_next;
        out_drop_reg <= out_drop_next;
    end

    assign item_stall     = (state_reg != S_IDLE);
    assign result_valid   = out_valid_reg;
    assign covered_length = out_len_reg;
    assign dropped        = out_drop_reg;

    // fill count never passes the store depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_MAX)
        else $error("fill count above store depth");

    // insert slot stays inside the store
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_INS_RD || state_reg == S_INS_WR) |-> pos_reg < CNT_MAX)
        else $error("insert slot out of range");

    // a new result only ever comes from the output hand-off state
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(state_reg == S_OUT))
        else $error("result raised outside hand-off");

    // the walk never runs on an empty store
    a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WLK_RD) |-> count_reg != '0)
        else $error("walk on empty store");

endmodule

`default_nettype wire
